// ===== rtl/core/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg
// shared types and constants for the rgba alpha compositor
// ----------------------------------------------------------------------------
package rac_pkg;

   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   typedef enum logic [1:0] {
      MODE_FADE    = 2'd0,
      MODE_FLATTEN = 2'd1,
      MODE_COMPOSE = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_MODE = 3'd0,
      CSR_FADE_GAIN  = 3'd1,
      CSR_BG_RED     = 3'd2,
      CSR_BG_GREEN   = 3'd3,
      CSR_BG_BLUE    = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/core/rac_mix.sv =====
// ----------------------------------------------------------------------------
// rac_mix
// one colour channel blend: floor((c0*(255-a) + c1*a) / 255)
// ----------------------------------------------------------------------------
module rac_mix
   import rac_pkg::*;
(
   input  logic [CHAN_W-1:0] c0,
   input  logic [CHAN_W-1:0] c1,
   input  logic [CHAN_W-1:0] alpha,
   output logic [CHAN_W-1:0] mixed
);

   logic [CHAN_W-1:0]     inv_alpha;
   logic [2*CHAN_W-1:0]   term0;
   logic [2*CHAN_W-1:0]   term1;
   logic [2*CHAN_W-1:0]   sum;
   logic [2*CHAN_W:0]     quot;

   // 255 - a is the bitwise complement for an 8-bit a
   assign inv_alpha = ~alpha;
   assign term0     = (2*CHAN_W)'(c0) * (2*CHAN_W)'(inv_alpha);
   assign term1     = (2*CHAN_W)'(c1) * (2*CHAN_W)'(alpha);
   assign sum       = term0 + term1;

   // exact divide by 255 for sums up to 255*255
   assign quot  = (2*CHAN_W+1)'(sum) + (2*CHAN_W+1)'(1)
                + (2*CHAN_W+1)'(sum[2*CHAN_W-1:CHAN_W]);
   assign mixed = quot[2*CHAN_W-1:CHAN_W];

endmodule

// ===== rtl/core/rgba_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// rgba_alpha_compositor
// per-pixel rgba fade, flatten over background and overlay compose
// ----------------------------------------------------------------------------
// One pixel is taken per clock while req_stall is low. Each result passes
// through the input register, then the result register. The whole blend
// for a pixel sits in the single stage between those two registers: three
// 8x8 multiply pairs with their divide-by-255 correction, and the 8x16 alpha
// gain multiply. A stalled result stalls the input only when the input
// register is also full. Mode, gain and background registers are written
// through the csr port, and the user must write them only between streams;
// the block does not enforce this. Mode 3 passes the base pixel unchanged.
module rgba_alpha_compositor
   import rac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_base_red,
   input  logic [CHAN_W-1:0]     req_base_green,
   input  logic [CHAN_W-1:0]     req_base_blue,
   input  logic [CHAN_W-1:0]     req_base_alpha,
   input  logic [CHAN_W-1:0]     req_over_red,
   input  logic [CHAN_W-1:0]     req_over_green,
   input  logic [CHAN_W-1:0]     req_over_blue,
   input  logic [CHAN_W-1:0]     req_over_alpha,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_out_red,
   output logic [CHAN_W-1:0]     rsp_out_green,
   output logic [CHAN_W-1:0]     rsp_out_blue,
   output logic [CHAN_W-1:0]     rsp_out_alpha
);

   logic [1:0]        mode_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [CHAN_W-1:0] bg_red_ff, bg_green_ff, bg_blue_ff;

   logic              s1_valid_ff;
   logic [CHAN_W-1:0] br_ff, bg_ff, bb_ff, ba_ff;
   logic [CHAN_W-1:0] or_ff, og_ff, ob_ff, oa_ff;

   logic              s2_valid_ff;
   logic [CHAN_W-1:0] out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic [CHAN_W-1:0] out_red_in, out_green_in, out_blue_in, out_alpha_in;

   logic              s2_load;
   logic              s1_load;

   logic [CHAN_W-1:0] mix_c0_red, mix_c0_green, mix_c0_blue;
   logic [CHAN_W-1:0] mix_c1_red, mix_c1_green, mix_c1_blue;
   logic [CHAN_W-1:0] mix_alpha;
   logic [CHAN_W-1:0] mix_red, mix_green, mix_blue;

   logic [CHAN_W+GAIN_W-1:0] fade_prod;
   logic [GAIN_W-1:0]        fade_scaled;
   logic [CHAN_W-1:0]        fade_alpha;
   logic [CHAN_W:0]          alpha_sum;
   logic [CHAN_W-1:0]        sum_alpha;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_FADE;
         gain_ff     <= GAIN_RESET;
         bg_red_ff   <= '0;
         bg_green_ff <= '0;
         bg_blue_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLEND_MODE: mode_ff     <= csr_wdata[1:0];
            CSR_FADE_GAIN:  gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_BG_RED:     bg_red_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_BG_GREEN:   bg_green_ff <= csr_wdata[CHAN_W-1:0];
            CSR_BG_BLUE:    bg_blue_ff  <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         br_ff <= req_base_red;
         bg_ff <= req_base_green;
         bb_ff <= req_base_blue;
         ba_ff <= req_base_alpha;
         or_ff <= req_over_red;
         og_ff <= req_over_green;
         ob_ff <= req_over_blue;
         oa_ff <= req_over_alpha;
      end
   end

   // blend operand selection
   always_comb begin
      if (mode_ff == MODE_FLATTEN) begin
         mix_c0_red   = bg_red_ff;
         mix_c0_green = bg_green_ff;
         mix_c0_blue  = bg_blue_ff;
         mix_c1_red   = br_ff;
         mix_c1_green = bg_ff;
         mix_c1_blue  = bb_ff;
         mix_alpha    = ba_ff;
      end else begin
         mix_c0_red   = br_ff;
         mix_c0_green = bg_ff;
         mix_c0_blue  = bb_ff;
         mix_c1_red   = or_ff;
         mix_c1_green = og_ff;
         mix_c1_blue  = ob_ff;
         mix_alpha    = oa_ff;
      end
   end

   rac_mix u_mix_red (
      .c0    (mix_c0_red),
      .c1    (mix_c1_red),
      .alpha (mix_alpha),
      .mixed (mix_red)
   );

   rac_mix u_mix_green (
      .c0    (mix_c0_green),
      .c1    (mix_c1_green),
      .alpha (mix_alpha),
      .mixed (mix_green)
   );

   rac_mix u_mix_blue (
      .c0    (mix_c0_blue),
      .c1    (mix_c1_blue),
      .alpha (mix_alpha),
      .mixed (mix_blue)
   );

   // alpha paths
   assign fade_prod   = (CHAN_W+GAIN_W)'(ba_ff) * (CHAN_W+GAIN_W)'(gain_ff);
   assign fade_scaled = fade_prod[CHAN_W+GAIN_W-1:CHAN_W];
   assign fade_alpha  = (fade_scaled > GAIN_W'(FULL_SCALE)) ? FULL_SCALE
                                                            : fade_scaled[CHAN_W-1:0];
   assign alpha_sum   = (CHAN_W+1)'(ba_ff) + (CHAN_W+1)'(oa_ff);
   assign sum_alpha   = alpha_sum[CHAN_W] ? FULL_SCALE : alpha_sum[CHAN_W-1:0];

   always_comb begin
      out_red_in   = br_ff;
      out_green_in = bg_ff;
      out_blue_in  = bb_ff;
      out_alpha_in = ba_ff;
      case (mode_ff)
         MODE_FADE: begin
            out_alpha_in = fade_alpha;
         end
         MODE_FLATTEN: begin
            out_red_in   = mix_red;
            out_green_in = mix_green;
            out_blue_in  = mix_blue;
            out_alpha_in = FULL_SCALE;
         end
         MODE_COMPOSE: begin
            out_red_in   = mix_red;
            out_green_in = mix_green;
            out_blue_in  = mix_blue;
            out_alpha_in = sum_alpha;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
         out_alpha_ff <= out_alpha_in;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_alpha = out_alpha_ff;

`ifndef NO_ASSERTIONS
   // a stalled request always has a held pixel in front of it
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stall without a held pixel");

   // a held pixel that cannot move on stays held
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> s1_valid_ff)
      else $error("held pixel lost while result stalled");

   // a waiting result with a full input stage blocks new transfers
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && rsp_stall && s1_valid_ff) |-> req_stall)
      else $error("transfer accepted into a full pipeline");

   // flatten always reports opaque alpha
   a_flatten_alpha: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && mode_ff == MODE_FLATTEN)
      |=> (rsp_out_alpha == FULL_SCALE))
      else $error("flatten result alpha not opaque");
`endif

endmodule

// ===== test/rgba_alpha_compositor_tb.sv =====
// ----------------------------------------------------------------------------
// rgba_alpha_compositor_tb
// Tests the rgba alpha compositor in all four modes. A driver sends queued
// pixels and a monitor checks each result pixel against a model built into
// this file. Both sides insert random gaps, and a long receiver stall makes
// the block stall its input. Every register is rewritten between phases,
// and the settings include the extreme values.
// ----------------------------------------------------------------------------
module rgba_alpha_compositor_tb;
   import rac_pkg::*;

   localparam logic [1:0] MODE_PASS = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] base_red;
      logic [CHAN_W-1:0] base_green;
      logic [CHAN_W-1:0] base_blue;
      logic [CHAN_W-1:0] base_alpha;
      logic [CHAN_W-1:0] over_red;
      logic [CHAN_W-1:0] over_green;
      logic [CHAN_W-1:0] over_blue;
      logic [CHAN_W-1:0] over_alpha;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAN_W-1:0]     req_base_red = '0;
   logic [CHAN_W-1:0]     req_base_green = '0;
   logic [CHAN_W-1:0]     req_base_blue = '0;
   logic [CHAN_W-1:0]     req_base_alpha = '0;
   logic [CHAN_W-1:0]     req_over_red = '0;
   logic [CHAN_W-1:0]     req_over_green = '0;
   logic [CHAN_W-1:0]     req_over_blue = '0;
   logic [CHAN_W-1:0]     req_over_alpha = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_red;
   logic [CHAN_W-1:0]     rsp_out_green;
   logic [CHAN_W-1:0]     rsp_out_blue;
   logic [CHAN_W-1:0]     rsp_out_alpha;

   // register copies used for prediction
   logic [1:0]        cfg_mode = MODE_FADE;
   logic [GAIN_W-1:0] cfg_gain = GAIN_RESET;
   logic [CHAN_W-1:0] cfg_bg_red = '0;
   logic [CHAN_W-1:0] cfg_bg_green = '0;
   logic [CHAN_W-1:0] cfg_bg_blue = '0;

   pixel_type  pixels_to_send[$];
   result_type predicted_pixels[$];
   pixel_type  offered_pixel;
   int      queued_total = 0;
   int      accepted_count = 0;
   int      checked_count = 0;
   int      error_count = 0;
   int      send_gap = 0;
   int      stall_left = 0;
   int      hold_left = 0;
   int      next_hold_at = 100;
   bit      steady = 1'b0;

   rgba_alpha_compositor uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_base_red   (req_base_red),
      .req_base_green (req_base_green),
      .req_base_blue  (req_base_blue),
      .req_base_alpha (req_base_alpha),
      .req_over_red   (req_over_red),
      .req_over_green (req_over_green),
      .req_over_blue  (req_over_blue),
      .req_over_alpha (req_over_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] c0,
                                                       input logic [CHAN_W-1:0] c1,
                                                       input logic [CHAN_W-1:0] a);
      int unsigned full;
      int unsigned sum;
      full = FULL_SCALE;
      sum  = int'(c0) * (full - int'(a)) + int'(c1) * int'(a);
      return CHAN_W'(sum / full);
   endfunction

   function automatic result_type composite_pixel(input pixel_type p);
      result_type  r;
      int unsigned level;
      r = '{p.base_red, p.base_green, p.base_blue, p.base_alpha};
      case (cfg_mode)
         MODE_FADE: begin
            level   = (int'(p.base_alpha) * int'(cfg_gain)) >> 8;
            r.alpha = level > FULL_SCALE ? FULL_SCALE : CHAN_W'(level);
         end
         MODE_FLATTEN: begin
            r.red   = blend_channel(cfg_bg_red, p.base_red, p.base_alpha);
            r.green = blend_channel(cfg_bg_green, p.base_green, p.base_alpha);
            r.blue  = blend_channel(cfg_bg_blue, p.base_blue, p.base_alpha);
            r.alpha = FULL_SCALE;
         end
         MODE_COMPOSE: begin
            r.red   = blend_channel(p.base_red, p.over_red, p.over_alpha);
            r.green = blend_channel(p.base_green, p.over_green, p.over_alpha);
            r.blue  = blend_channel(p.base_blue, p.over_blue, p.over_alpha);
            level   = int'(p.base_alpha) + int'(p.over_alpha);
            r.alpha = level > FULL_SCALE ? FULL_SCALE : CHAN_W'(level);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(9))
         0: return '0;
         1: return FULL_SCALE;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BLEND_MODE: cfg_mode = data[1:0];
         CSR_FADE_GAIN:  cfg_gain = data;
         CSR_BG_RED:     cfg_bg_red = data[CHAN_W-1:0];
         CSR_BG_GREEN:   cfg_bg_green = data[CHAN_W-1:0];
         CSR_BG_BLUE:    cfg_bg_blue = data[CHAN_W-1:0];
         default: begin
         end
      endcase
   endtask

   // unused upper data bits carry noise
   task automatic set_config(input logic [1:0] mode, input logic [GAIN_W-1:0] gain,
                             input logic [CHAN_W-1:0] bg_r, input logic [CHAN_W-1:0] bg_g,
                             input logic [CHAN_W-1:0] bg_b);
      write_csr(CSR_BLEND_MODE, CSR_DATA_W'(($urandom() & 32'hFFFC) | mode));
      write_csr(CSR_FADE_GAIN, gain);
      write_csr(CSR_BG_RED, CSR_DATA_W'(($urandom() & 32'hFF00) | bg_r));
      write_csr(CSR_BG_GREEN, CSR_DATA_W'(($urandom() & 32'hFF00) | bg_g));
      write_csr(CSR_BG_BLUE, CSR_DATA_W'(($urandom() & 32'hFF00) | bg_b));
   endtask

   task automatic queue_pixel(input logic [7:0] br, input logic [7:0] bgn,
                              input logic [7:0] bb, input logic [7:0] ba,
                              input logic [7:0] orr, input logic [7:0] ogn,
                              input logic [7:0] ob, input logic [7:0] oa);
      pixel_type p;
      p = '{br, bgn, bb, ba, orr, ogn, ob, oa};
      pixels_to_send.push_back(p);
      queued_total++;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (accepted_count != queued_total || predicted_pixels.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      bit held;
      held = req_valid && req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_pixels.push_back(composite_pixel(offered_pixel));
            accepted_count <= accepted_count + 1;
            send_gap = steady ? 0 : pick_gap();
         end
         if (!held) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
               offered_pixel = pixels_to_send.pop_front();
               req_base_red   <= offered_pixel.base_red;
               req_base_green <= offered_pixel.base_green;
               req_base_blue  <= offered_pixel.base_blue;
               req_base_alpha <= offered_pixel.base_alpha;
               req_over_red   <= offered_pixel.over_red;
               req_over_green <= offered_pixel.over_green;
               req_over_blue  <= offered_pixel.over_blue;
               req_over_alpha <= offered_pixel.over_alpha;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block fills up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         next_hold_at <= 100;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_count >= next_hold_at) begin
         hold_left <= 250;
         next_hold_at <= next_hold_at + 600;
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_pixels.size() == 0) begin
               report($sformatf("unexpected result transfer %0d", checked_count));
            end else begin
               want = predicted_pixels.pop_front();
               if (rsp_out_red !== want.red)
                  report($sformatf("pixel %0d red: got %0d expected %0d",
                                   checked_count, rsp_out_red, want.red));
               if (rsp_out_green !== want.green)
                  report($sformatf("pixel %0d green: got %0d expected %0d",
                                   checked_count, rsp_out_green, want.green));
               if (rsp_out_blue !== want.blue)
                  report($sformatf("pixel %0d blue: got %0d expected %0d",
                                   checked_count, rsp_out_blue, want.blue));
               if (rsp_out_alpha !== want.alpha)
                  report($sformatf("pixel %0d alpha: got %0d expected %0d",
                                   checked_count, rsp_out_alpha, want.alpha));
            end
            checked_count++;
         end
         if (stall_left == 0 && !steady && $urandom_range(3) == 0)
            stall_left = pick_gap();
         rsp_stall <= (stall_left != 0) || (hold_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   initial begin
      #(12 * 800000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [GAIN_W-1:0] gain;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: fade at unity gain
      queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA);
      queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55);
      drain();

      // fade overflow and zero gain
      set_config(MODE_FADE, 16'hFFFF, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h80, 8'h81, 8'h82, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'hFE, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      drain();
      set_config(MODE_FADE, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h01, 8'h02, 8'h03, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40);
      drain();

      // flatten: transparent, opaque, half
      set_config(MODE_FLATTEN, GAIN_RESET, 8'hFF, 8'h00, 8'h80);
      queue_pixel(8'h00, 8'hFF, 8'h11, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'h00, 8'hFF, 8'h11, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h00, 8'hFF, 8'hEE, 8'h80, 8'hAA, 8'h55, 8'hAA, 8'h55);
      drain();

      // compose: clear and opaque overlay, alpha sum saturating and exact
      set_config(MODE_COMPOSE, 16'h0100, 8'h00, 8'h00, 8'h00);
      queue_pixel(8'h10, 8'h20, 8'h30, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      queue_pixel(8'h10, 8'h20, 8'h30, 8'h40, 8'hFF, 8'h00, 8'h80, 8'hFF);
      queue_pixel(8'hFF, 8'h00, 8'h80, 8'hC8, 8'h00, 8'hFF, 8'h7F, 8'h64);
      queue_pixel(8'h00, 8'hFF, 8'h01, 8'h9B, 8'hFF, 8'h00, 8'hFE, 8'h64);
      drain();

      // unused mode passes the base pixel through
      set_config(MODE_PASS, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h01, 8'h02, 8'h03, 8'h04);
      queue_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
      drain();

      for (int k = 0; k < 12; k++) begin
         case ($urandom_range(4))
            0: gain = '0;
            1: gain = 16'hFFFF;
            2: gain = GAIN_RESET;
            default: gain = GAIN_W'($urandom_range(767));
         endcase
         set_config(2'(k % 4), gain, rand_chan(), rand_chan(), rand_chan());
         steady = (k % 3 == 1);
         for (int n = 0; n < 150; n++)
            queue_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        rand_chan(), rand_chan(), rand_chan(), rand_chan());
         drain();
      end

      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
